### design/pit_pkg.sv
// Shared types, constants and helper functions for the point-in-polygon test unit.
// No dependencies; every other design file but pit_ram refers to this package by scoped names.
`default_nettype none
package pit_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int VERTEX_W     = 2 * COORD_W;
  localparam int SLOT_IN_W    = 6;

  localparam int COUNT_W      = 7;
  localparam int CMP_W        = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // APB register file
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  // sequencer drain length: vertex RAM read register plus the edge pipeline stages
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] yi;
    logic signed [COORD_W-1:0] xj;
    logic signed [COORD_W-1:0] yj;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic toggle;
  } edge_rsp_t;

  // Slot of a load: index wrapped to the store depth (constant lookup).
  function automatic logic [IDX_W-1:0] slot_of(input logic [SLOT_IN_W-1:0] idx);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = 0; k < (1 << SLOT_IN_W); k++) begin
      if (idx == SLOT_IN_W'(k)) r = IDX_W'(k % MAX_VERTICES);
    end
    return r;
  endfunction

  // Vertex count clamped to the store depth.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] cnt);
    logic [CNT_W-1:0] r;
    if (CMP_W'(cnt) > CMP_W'(MAX_VERTICES)) r = CNT_W'(MAX_VERTICES);
    else                                     r = CNT_W'(cnt);
    return r;
  endfunction

endpackage
`default_nettype wire

### design/pit_if.sv
// Valid/ready stream interfaces for the point channel and the result channel.
// Depends on pit_pkg for field widths.
`default_nettype none
interface pit_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [pit_pkg::SLOT_IN_W-1:0]      vertex_index;
  logic signed [pit_pkg::COORD_W-1:0] coord_x;
  logic signed [pit_pkg::COORD_W-1:0] coord_y;

  modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pit_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface
`default_nettype wire

### design/pit_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.
`default_nettype none
module pit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/pit_cfg.sv
// APB register block: holds vertex_count.
// Depends on pit_pkg for address/data widths and register index.
`default_nettype none
module pit_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pit_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [pit_pkg::PDATA_W-1:0]   pwdata,
  output logic      [pit_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [pit_pkg::COUNT_W-1:0]   vertex_count
);

  logic reg_sel;
  logic wr_en;

  // word index = byte address / 4
  assign reg_sel = (paddr[2] == pit_pkg::REG_VERTEX_COUNT);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (wr_en && reg_sel) begin
      vertex_count <= pwdata[pit_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) prdata = pit_pkg::PDATA_W'(vertex_count);
  end

endmodule
`default_nettype wire

### design/pit_edge.sv
// Three-stage edge crossing pipeline: differences, cross products, compare.
// Depends on pit_pkg for edge_req_t / edge_rsp_t and widths.
`default_nettype none
module pit_edge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pit_pkg::edge_req_t req,
  output pit_pkg::edge_rsp_t      rsp
);

  // stage a: differences
  logic                             valid_a, cross_a, up_a;
  logic signed [pit_pkg::DIFF_W-1:0] dl, dyl, dxr, dyr;
  // stage b: products
  logic                             valid_b, cross_b, up_b;
  logic signed [pit_pkg::PROD_W-1:0] pl, pr;
  // stage c: toggle
  logic                             valid_c, toggle_c;

  function automatic logic signed [pit_pkg::DIFF_W-1:0] sdiff(
    input logic signed [pit_pkg::COORD_W-1:0] a,
    input logic signed [pit_pkg::COORD_W-1:0] b);
    return {a[pit_pkg::COORD_W-1], a} - {b[pit_pkg::COORD_W-1], b};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else begin
      valid_a <= req.valid;
      valid_b <= valid_a;
      valid_c <= valid_b;
    end
    // exactly one endpoint above the point's y
    cross_a <= (req.py < req.yi) != (req.py < req.yj);
    up_a    <= req.yj > req.yi;
    dl      <= sdiff(req.px, req.xi);
    dyl     <= sdiff(req.yj, req.yi);
    dxr     <= sdiff(req.xj, req.xi);
    dyr     <= sdiff(req.py, req.yi);

    cross_b <= cross_a;
    up_b    <= up_a;
    pl      <= pit_pkg::PROD_W'(dl) * pit_pkg::PROD_W'(dyl);
    pr      <= pit_pkg::PROD_W'(dxr) * pit_pkg::PROD_W'(dyr);

    // edge direction flips the sense of the compare
    toggle_c <= cross_b && (up_b ? (pl < pr) : (pl > pr));
  end

  assign rsp.valid  = valid_c;
  assign rsp.toggle = toggle_c;

endmodule
`default_nettype wire

### design/point_in_polygon_test_unit.sv
// Top level of the even-odd point-in-polygon test unit: sequencer, vertex RAM,
// edge pipeline and APB registers. Depends on pit_pkg, pit_if, pit_ram, pit_cfg, pit_edge.
//
//   channel | dir | word fields                              | notes
//   --------+-----+------------------------------------------+-----------------------------
//   point   | in  | action, vertex_index, coord_x, coord_y   | load vertex or test point
//   result  | out | inside_res                               | one word per test, none per load
//   apb     | cfg | paddr, pwdata, prdata                    | reg 0 = vertex_count
//
// Sequence: a load is written to the vertex RAM on acceptance. A test with n clamped
//   vertices runs accept, n + 1 RAM reads, edge pipeline drain and result handoff;
//   n = 0 skips reads and drain. The single vertex RAM read port sets the pace: one edge per cycle.
// Reset: rst, synchronous, clears sequencer, result valid and parity.
// Stalls: point.ready is high only between tests; a finished result sits in the
//   output register, and loads are taken while it waits for result.ready.
`default_nettype none
module point_in_polygon_test_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pit_in_if.sink                           point,
  pit_out_if.source                        result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pit_pkg::PADDR_W-1:0] paddr,
  input  wire logic [pit_pkg::PDATA_W-1:0] pwdata,
  output logic      [pit_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_DONE} state_t;

  state_t                              state;
  logic [pit_pkg::COUNT_W-1:0]         vertex_count;
  logic [pit_pkg::CNT_W-1:0]           n_edges;     // clamped count of current test
  logic [pit_pkg::CNT_W-1:0]           rd_cnt;      // read issue counter 0..n
  logic [pit_pkg::CNT_W-1:0]           rd_addr_full;
  logic [pit_pkg::DRAIN_W-1:0]         drain_cnt;
  logic                                rd_valid, rd_first;
  logic                                parity;
  logic                                out_valid, out_inside;
  logic signed [pit_pkg::COORD_W-1:0]  px, py;
  logic signed [pit_pkg::COORD_W-1:0]  prev_x, prev_y;   // vertex j
  logic                                accept, ram_we;
  logic [pit_pkg::VERTEX_W-1:0]        ram_rdata;
  pit_pkg::edge_req_t                  ereq;
  pit_pkg::edge_rsp_t                  ersp;

  pit_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .vertex_count
  );

  // nothing is taken while reset is held
  assign point.ready = (state == S_IDLE) && !rst;
  assign accept      = point.valid && point.ready;
  assign ram_we      = accept && (point.action == pit_pkg::ACT_LOAD);

  // first read fetches the last vertex (j of edge 0), then vertices 0..n-1
  assign rd_addr_full = (rd_cnt == '0) ? (n_edges - 1'b1) : (rd_cnt - 1'b1);

  // vertex word = {y, x}
  pit_ram #(
    .WIDTH(pit_pkg::VERTEX_W),
    .DEPTH(pit_pkg::MAX_VERTICES)
  ) u_vram (
    .clk,
    .we    (ram_we),
    .waddr (pit_pkg::slot_of(point.vertex_index)),
    .wdata ({point.coord_y, point.coord_x}),
    .raddr (rd_addr_full[pit_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    ereq.valid = rd_valid && !rd_first;
    ereq.px    = px;
    ereq.py    = py;
    ereq.xi    = ram_rdata[pit_pkg::COORD_W-1:0];
    ereq.yi    = ram_rdata[pit_pkg::VERTEX_W-1:pit_pkg::COORD_W];
    ereq.xj    = prev_x;
    ereq.yj    = prev_y;
  end

  pit_edge u_edge (.clk, .rst, .req(ereq), .rsp(ersp));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_valid  <= 1'b0;
      rd_first  <= 1'b0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
      rd_cnt    <= '0;
      drain_cnt <= '0;
      n_edges   <= '0;
    end else begin
      rd_valid <= (state == S_WALK);
      rd_first <= (rd_cnt == '0);

      if (rd_valid) begin
        prev_x <= ram_rdata[pit_pkg::COORD_W-1:0];
        prev_y <= ram_rdata[pit_pkg::VERTEX_W-1:pit_pkg::COORD_W];
      end

      if (ersp.valid) parity <= parity ^ ersp.toggle;

      // in S_DONE the output register is refilled below instead
      if (out_valid && result.ready && (state != S_DONE)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept && (point.action == pit_pkg::ACT_TEST)) begin
            px      <= point.coord_x;
            py      <= point.coord_y;
            parity  <= 1'b0;
            rd_cnt  <= '0;
            n_edges <= pit_pkg::clamp_count(vertex_count);
            // empty polygon: straight to the result
            if (pit_pkg::clamp_count(vertex_count) == '0) state <= S_DONE;
            else                                          state <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_cnt == n_edges) begin
            state     <= S_DRAIN;
            drain_cnt <= '0;
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          rd_cnt <= '0;
          if (drain_cnt == pit_pkg::DRAIN_W'(pit_pkg::DRAIN_CYCLES - 1)) state <= S_DONE;
          else drain_cnt <= drain_cnt + 1'b1;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_inside <= parity;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid      = out_valid;
  assign result.inside_res = out_inside;

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for point_in_polygon_test_unit: even-odd polygon tests.
// Depends on pit_pkg and the pit_in_if / pit_out_if stream interfaces.
module testbench;
  import pit_pkg::*;

  // Cycles with no word moved before the run is declared hung. The worst
  // legal quiet stretch is the long receiver hold plus one 64-vertex walk.
  localparam int WATCHDOG_LIMIT = 5000;
  // Settle wait: covers a whole test over the full 64-vertex store.
  localparam int DRAIN_GUARD    = 80;
  localparam int RANDOM_WORDS   = 630;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 30;

  localparam logic signed [COORD_W-1:0] ONE   = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  // Vertex counts for the first random phases: both extremes, saturation,
  // the degenerate one- and two-vertex cases. Later phases pick at random.
  localparam int FIRST_COUNTS [6] = '{127, 0, 64, 1, 2, 65};

  typedef struct packed {
    logic                      action;
    logic [SLOT_IN_W-1:0]      slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_word_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  pit_in_if  pin ();
  pit_out_if pout ();

  point_in_polygon_test_unit uut (
    .clk     (clk),
    .rst     (rst),
    .point   (pin),
    .result  (pout),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the vertex store and the count register.
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] vx_store [MAX_VERTICES];
  logic signed [COORD_W-1:0] vy_store [MAX_VERTICES];
  logic [COUNT_W-1:0]        vertex_count_cfg = '0;

  point_word_t pending_words [$];     // stimulus not yet offered
  logic        parity_expected [$];   // one bit per accepted test, oldest first

  int   n_queued = 0, n_accepted = 0;
  int   n_loads = 0, n_tests = 0, n_checked = 0, n_inside = 0, n_settings = 0;
  int   error_count = 0;
  logic word_taken = 1'b0;
  logic press_now = 1'b0;

  // Even-odd crossing parity of (px, py) against the first cnt stored
  // vertices, cnt saturating at the store depth. Edge j -> i, j starting at
  // the last vertex. The crossing test is an exact cross-multiplication in
  // 66-bit signed arithmetic, so no division and no rounding.
  function automatic logic even_odd_parity(input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py,
                                           input logic [COUNT_W-1:0] cnt);
    int unsigned               n, j;
    logic                      odd;
    logic signed [COORD_W-1:0] xi, yi, xj, yj;
    logic signed [PROD_W-1:0]  a, b, c, d, lhs, rhs;
    n   = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
    odd = 1'b0;
    j   = n - 1;
    for (int i = 0; i < n; i++) begin
      xi = vx_store[i];
      yi = vy_store[i];
      xj = vx_store[j];
      yj = vy_store[j];
      // only edges with exactly one end strictly above py; horizontal never
      if ((py < yi) != (py < yj)) begin
        a   = px - xi;
        b   = yj - yi;
        c   = xj - xi;
        d   = py - yi;
        lhs = a * b;
        rhs = c * d;
        if (yj > yi) odd ^= (lhs < rhs);
        else         odd ^= (lhs > rhs);
      end
      j = i;
    end
    return odd;
  endfunction

  // ---------------------------------------------------------------------------
  // Point channel driver: bursts of random length with random gaps; a quarter
  // of the bursts are followed by no gap at all, giving idle-free stretches.
  // ---------------------------------------------------------------------------
  int burst_left = 0, gap_left = 0;

  always @(negedge clk) begin : point_driver
    point_word_t w;
    if (rst) begin
      pin.valid <= 1'b0;
    end else if (!pin.valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        pin.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        pin.action       <= w.action;
        pin.vertex_index <= w.slot;
        pin.coord_x      <= w.x;
        pin.coord_y      <= w.y;
        pin.valid        <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        pin.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result channel ready: cycles through four stall patterns (always ready,
  // periodic, random, long blocks). Once press_now is raised, ready is held
  // low for HOLD_CYCLES so the block fills up and stops taking points.
  // ---------------------------------------------------------------------------
  int   rx_cyc = 0, hold_left = 0;
  logic press_done = 1'b0;

  always @(negedge clk) begin : result_ready_gen
    logic rdy;
    rx_cyc++;
    if (press_now && !press_done) begin
      press_done = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      case ((rx_cyc / 300) % 4)
        0:       rdy = 1'b1;
        1:       rdy = (rx_cyc % 5) != 0;
        2:       rdy = $urandom_range(0, 1);
        default: rdy = ((rx_cyc / 16) % 2) == 0;
      endcase
    end
    pout.ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted point word, checks every result word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic exp_bit;
    word_taken <= !rst && pin.valid && pin.ready;
    if (!rst && pin.valid && pin.ready) begin
      n_accepted++;
      if (pin.action == ACT_LOAD) begin
        vx_store[pin.vertex_index % MAX_VERTICES] = pin.coord_x;
        vy_store[pin.vertex_index % MAX_VERTICES] = pin.coord_y;
        n_loads++;
      end else begin
        parity_expected.push_back(even_odd_parity(pin.coord_x, pin.coord_y,
                                                  vertex_count_cfg));
        n_tests++;
      end
    end
    if (!rst && pout.valid && pout.ready) begin
      if (parity_expected.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: inside_res %0b arrived with no test pending, expected none",
                   $realtime, pout.inside_res);
      end else begin
        exp_bit = parity_expected.pop_front();
        n_checked++;
        if (exp_bit) n_inside++;
        if (pout.inside_res !== exp_bit) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result %0d inside_res expected %0b actual %0b",
                     $realtime, n_checked, exp_bit, pout.inside_res);
        end
      end
    end
  end

  // Watchdog: any accepted word or APB access restarts the count.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (pin.valid && pin.ready) || (pout.valid && pout.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic act, input logic [SLOT_IN_W-1:0] slot,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    point_word_t w;
    w.action = act;
    w.slot   = slot;
    w.x      = x;
    w.y      = y;
    pending_words.push_back(w);
    n_queued++;
  endtask

  // Block idle: everything offered is taken, every result is back, and the
  // trailing loads have had time to land.
  task automatic settle();
    while (pending_words.size() > 0 || n_accepted != n_queued || parity_expected.size() > 0)
      @(negedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write vertex_count while idle, then read it back.
  task automatic set_vertex_count(input int unsigned value);
    logic [PDATA_W-1:0] rd;
    logic [PADDR_W-1:0] addr;
    addr = PADDR_W'(4 * REG_VERTEX_COUNT);
    settle();
    apb_access(1'b1, addr, PDATA_W'(value), rd);
    vertex_count_cfg = COUNT_W'(value);
    n_settings++;
    apb_access(1'b0, addr, '0, rd);
    if (rd !== PDATA_W'(value)) begin
      error_count++;
      $display("%0t: vertex_count readback expected %0d actual %0d", $realtime, value, rd);
    end
  endtask

  // Random coordinate within +-2^sh of c (wraps at the 32-bit boundary).
  function automatic logic signed [COORD_W-1:0] near_coord(input logic signed [COORD_W-1:0] c,
                                                           input int unsigned sh);
    longint span, off;
    span = longint'(1) << sh;
    off  = longint'($urandom_range(0, 32'(2 * span))) - span;
    return 32'(longint'(c) + off);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
    logic signed [COORD_W-1:0] cx, cy, tx, ty;
    int unsigned vc, n, sh, r, k, ntests, n_directed, phase;

    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    pin.valid        = 1'b0;
    pin.action       = ACT_LOAD;
    pin.vertex_index = '0;
    pin.coord_x      = '0;
    pin.coord_y      = '0;
    pout.ready       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed ---
    // zero vertices (reset count): always outside
    send_word(ACT_TEST, '0, '0, '0);
    // one vertex: its only edge is horizontal
    set_vertex_count(1);
    send_word(ACT_LOAD, '0, ONE, ONE);
    send_word(ACT_TEST, '1, '0, ONE);
    send_word(ACT_TEST, '0, '0, '0);
    // unit square: inside, outside, on a horizontal edge, on a vertical edge,
    // at a vertex height, and the coordinate extremes
    set_vertex_count(4);
    send_word(ACT_LOAD, 6'd0, -ONE, -ONE);
    send_word(ACT_LOAD, 6'd1,  ONE, -ONE);
    send_word(ACT_LOAD, 6'd2,  ONE,  ONE);
    send_word(ACT_LOAD, 6'd3, -ONE,  ONE);
    send_word(ACT_TEST, '0, '0, '0);
    send_word(ACT_TEST, '0, 2 * ONE, '0);
    send_word(ACT_TEST, '0, '0, -ONE);
    send_word(ACT_TEST, '0, -ONE, '0);
    send_word(ACT_TEST, '0, C_MAX, C_MIN);
    send_word(ACT_TEST, '0, C_MIN, C_MAX);
    // triangle spanning the full coordinate range; top slot written too
    set_vertex_count(3);
    send_word(ACT_LOAD, 6'd0, C_MIN, C_MIN);
    send_word(ACT_LOAD, 6'd1, C_MAX, C_MIN);
    send_word(ACT_LOAD, 6'd2, '0, C_MAX);
    send_word(ACT_LOAD, 6'd63, C_MAX, C_MAX);
    send_word(ACT_TEST, '0, '0, '0);
    send_word(ACT_TEST, '0, C_MIN, C_MIN);
    send_word(ACT_TEST, '0, C_MAX, '0);
    send_word(ACT_TEST, '0, C_MAX, C_MAX);
    n_directed = n_queued;

    // --- random phases ---
    // Each phase: set a count, load a random polygon into slots 0..n-1 so no
    // unwritten vertex is ever read, then probe it. Horizontal edges, points
    // at vertex heights and columns are made on purpose; a few words are
    // stray loads or points anywhere in the plane.
    phase = 0;
    while (n_queued - n_directed < RANDOM_WORDS) begin
      if (phase < 6) begin
        vc = FIRST_COUNTS[phase];
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7)       vc = $urandom_range(3, 12);
        else if (r == 7) vc = $urandom_range(13, 63);
        else if (r == 8) vc = $urandom_range(66, 127);
        else             vc = $urandom_range(0, 2);
      end
      set_vertex_count(vc);
      if (phase == 6) press_now = 1'b1;   // sender keeps offering meanwhile
      n  = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
      cx = $urandom;
      cy = $urandom;
      sh = $urandom_range(2, 30);
      for (k = 0; k < n; k++) begin
        poly_x[k] = near_coord(cx, sh);
        poly_y[k] = (k > 0 && $urandom_range(0, 4) == 0) ? poly_y[k-1] : near_coord(cy, sh);
        send_word(ACT_LOAD, SLOT_IN_W'(k), poly_x[k], poly_y[k]);
      end
      ntests = $urandom_range(6, 20);
      for (int t = 0; t < ntests; t++) begin
        r  = $urandom_range(0, 15);
        tx = near_coord(cx, sh);
        ty = near_coord(cy, sh);
        if (r == 0) begin
          k  = $urandom_range(0, MAX_VERTICES - 1);
          tx = $urandom;
          ty = $urandom;
          if (k < n) begin
            poly_x[k] = tx;
            poly_y[k] = ty;
          end
          send_word(ACT_LOAD, SLOT_IN_W'(k), tx, ty);
        end else begin
          if (r == 1) begin
            tx = $urandom;
            ty = $urandom;
          end else if (r == 2) begin
            tx = $urandom_range(0, 1) ? C_MAX : C_MIN;
            ty = $urandom_range(0, 1) ? C_MAX : C_MIN;
          end else if (r <= 4 && n > 0) begin
            ty = poly_y[$urandom_range(0, n - 1)];
          end else if (r == 5 && n > 0) begin
            tx = poly_x[$urandom_range(0, n - 1)];
          end
          send_word(ACT_TEST, SLOT_IN_W'($urandom), tx, ty);
        end
      end
      phase++;
    end

    settle();
    $display("covered %0d vertex loads and %0d point tests (%0d inside) over %0d count settings",
             n_loads, n_tests, n_inside, n_settings);
    $display("counts included 0, 1, 64 and saturating values; one long result stall applied");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
